[sv/rme_pkg.sv]
// ----------------------------------------------------------------------------
// rme_pkg
// Opcodes, masks, instruction lengths and shared types of the register
// machine execute unit.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int REGISTER_COUNT = 8;
  localparam int REG_INDEX_W    = $clog2(REGISTER_COUNT);

  localparam logic [7:0] MAJOR_CTRL  = 8'h00;
  localparam logic [7:0] MAJOR_ARITH = 8'h01;
  localparam logic [7:0] MAJOR_LOAD  = 8'h02;
  localparam logic [7:0] MAJOR_MUL   = 8'h03;

  localparam logic [7:0] MINOR_NOP  = 8'h00;
  localparam logic [7:0] MINOR_HALT = 8'h01;

  localparam logic [3:0] ARITH_INC   = 4'h0;
  localparam logic [3:0] ARITH_DEC   = 4'h8;
  localparam logic [3:0] ARITH_ADD64 = 4'h4;
  localparam logic [3:0] ARITH_ADD32 = 4'h5;
  localparam logic [3:0] ARITH_ADD8  = 4'h7;
  localparam logic [3:0] ARITH_SUB64 = 4'hC;
  localparam logic [3:0] ARITH_SUB32 = 4'hD;
  localparam logic [3:0] ARITH_SUB8  = 4'hF;

  localparam logic [3:0] LOAD_IMM64   = 4'h0;
  localparam logic [3:0] LOAD_IMM32   = 4'h1;
  localparam logic [3:0] LOAD_IMM8    = 4'h3;
  localparam logic [3:0] LOAD_MERGE32 = 4'h5;
  localparam logic [3:0] LOAD_MERGE8  = 4'h7;

  localparam logic [7:0] MUL_R0 = 8'h00;
  localparam logic [7:0] MUL_R1 = 8'h01;
  localparam logic [7:0] MUL_R2 = 8'h02;
  localparam logic [7:0] MUL_R3 = 8'h04;

  localparam logic [3:0] ADV_SHORT = 4'd2;
  localparam logic [3:0] ADV_IMM64 = 4'd10;
  localparam logic [3:0] ADV_IMM32 = 4'd6;
  localparam logic [3:0] ADV_IMM8  = 4'd3;

  localparam logic [63:0] MASK_PARTIAL4 = 64'h7fff_ffff_0000_0000;
  localparam logic [63:0] MASK_PARTIAL1 = 64'h7fff_ffff_ffff_0000;

  typedef struct packed {
    logic                   is_mul;
    logic [63:0]            next_ip;
    logic                   halted;
    logic                   illegal;
    logic                   wr;
    logic [REG_INDEX_W-1:0] dest_index;
    logic [63:0]            dest_value;
    logic                   wr_hi;
    logic [63:0]            high_value;
  } exec_t;

  function automatic logic [REG_INDEX_W-1:0] read_index(input logic [7:0] major,
                                                        input logic [7:0] minor);
    logic [REG_INDEX_W-1:0] idx;
    idx = minor[REG_INDEX_W-1:0];
    if (major == MAJOR_MUL) begin
      idx = (minor == MUL_R3) ? REG_INDEX_W'(3) : REG_INDEX_W'(minor[1:0]);
    end
    return idx;
  endfunction

endpackage

[sv/rme_if.sv]
// ----------------------------------------------------------------------------
// rme_if
// Valid/ready channels for instructions and for execution results.
// ----------------------------------------------------------------------------
interface rme_instr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  major_op;
  logic [7:0]  minor_op;
  logic [63:0] immediate;

  modport source (output valid, output major_op, output minor_op, output immediate,
                  input ready);
  modport sink (input valid, input major_op, input minor_op, input immediate,
                output ready);
endinterface

interface rme_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_ip;
  logic        halted;
  logic        illegal;
  logic [2:0]  dest_index;
  logic [63:0] dest_value;
  logic        high_written;
  logic [63:0] high_value;

  modport source (output valid, output next_ip, output halted, output illegal,
                  output dest_index, output dest_value, output high_written,
                  output high_value, input ready);
  modport sink (input valid, input next_ip, input halted, input illegal,
                input dest_index, input dest_value, input high_written,
                input high_value, output ready);
endinterface

[sv/rme_mul.sv]
// ----------------------------------------------------------------------------
// rme_mul
// Unsigned 64x64 multiplier: four registered 32x32 partial products, summed
// into the exact 128-bit product in the following cycle.
// ----------------------------------------------------------------------------
module rme_mul (
  input  logic        clk,
  input  logic        load,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] lo,
  output logic [63:0] hi
);

  logic [63:0] p00;
  logic [63:0] p01;
  logic [63:0] p10;
  logic [63:0] p11;
  logic [33:0] mid;

  always_ff @(posedge clk) begin
    if (load) begin
      p00 <= 64'(a[31:0]) * 64'(b[31:0]);
      p01 <= 64'(a[31:0]) * 64'(b[63:32]);
      p10 <= 64'(a[63:32]) * 64'(b[31:0]);
      p11 <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  always_comb begin
    mid = {2'b00, p00[63:32]} + {2'b00, p01[31:0]} + {2'b00, p10[31:0]};
    lo  = {mid[31:0], p00[31:0]};
    hi  = p11 + {32'd0, p01[63:32]} + {32'd0, p10[63:32]} + {62'd0, mid[33:32]};
  end

endmodule

[sv/rme_decode.sv]
// ----------------------------------------------------------------------------
// rme_decode
// Decodes one instruction and computes its register write, pointer update
// and halt status from the current machine state.
// ----------------------------------------------------------------------------
module rme_decode (
  input  logic                           stopped,
  input  logic [63:0]                    ip,
  input  logic [7:0]                     major_op,
  input  logic [7:0]                     minor_op,
  input  logic [63:0]                    immediate,
  input  logic [63:0]                    operand,
  input  logic [63:0]                    mul_lo,
  input  logic [63:0]                    mul_hi,
  output rme_pkg::exec_t                 exec
);

  logic                            bad;
  logic                            halt;
  logic                            wr;
  logic                            wr_hi;
  logic                            is_mul;
  logic                            sub;
  logic [3:0]                      adv;
  logic [63:0]                     val;
  logic [63:0]                     hval;
  logic [63:0]                     addend;
  logic [rme_pkg::REG_INDEX_W-1:0] dest;
  logic [63:0]                     imm32;
  logic [63:0]                     imm8;

  always_comb begin
    bad    = 1'b0;
    halt   = 1'b0;
    wr     = 1'b0;
    wr_hi  = 1'b0;
    is_mul = 1'b0;
    sub    = 1'b0;
    adv    = 4'd0;
    val    = 64'd0;
    hval   = 64'd0;
    addend = 64'd0;
    dest   = '0;
    imm32  = {32'd0, immediate[31:0]};
    imm8   = {56'd0, immediate[7:0]};

    if (stopped) begin
      halt = 1'b1;
    end else begin
      case (major_op)
        rme_pkg::MAJOR_CTRL: begin
          if (minor_op == rme_pkg::MINOR_NOP) begin
            adv = rme_pkg::ADV_SHORT;
          end else if (minor_op == rme_pkg::MINOR_HALT) begin
            halt = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        rme_pkg::MAJOR_ARITH: begin
          if (!minor_op[3]) begin
            wr   = 1'b1;
            dest = minor_op[rme_pkg::REG_INDEX_W-1:0];
            case (minor_op[7:4])
              rme_pkg::ARITH_INC: begin
                addend = 64'd1;
                adv    = rme_pkg::ADV_SHORT;
              end
              rme_pkg::ARITH_DEC: begin
                addend = 64'd1;
                sub    = 1'b1;
                adv    = rme_pkg::ADV_SHORT;
              end
              rme_pkg::ARITH_ADD64: begin
                addend = immediate;
                adv    = rme_pkg::ADV_IMM64;
              end
              rme_pkg::ARITH_ADD32: begin
                addend = imm32;
                adv    = rme_pkg::ADV_IMM32;
              end
              rme_pkg::ARITH_ADD8: begin
                addend = imm8;
                adv    = rme_pkg::ADV_IMM8;
              end
              rme_pkg::ARITH_SUB64: begin
                addend = immediate;
                sub    = 1'b1;
                adv    = rme_pkg::ADV_IMM64;
              end
              rme_pkg::ARITH_SUB32: begin
                addend = imm32;
                sub    = 1'b1;
                adv    = rme_pkg::ADV_IMM32;
              end
              rme_pkg::ARITH_SUB8: begin
                addend = imm8;
                sub    = 1'b1;
                adv    = rme_pkg::ADV_IMM8;
              end
              default: begin
                wr  = 1'b0;
                bad = 1'b1;
              end
            endcase
            val = sub ? (operand - addend) : (operand + addend);
          end else begin
            bad = 1'b1;
          end
        end
        rme_pkg::MAJOR_LOAD: begin
          if (!minor_op[3]) begin
            wr   = 1'b1;
            dest = minor_op[rme_pkg::REG_INDEX_W-1:0];
            case (minor_op[7:4])
              rme_pkg::LOAD_IMM64: begin
                val = immediate;
                adv = rme_pkg::ADV_IMM64;
              end
              rme_pkg::LOAD_IMM32: begin
                val = imm32;
                adv = rme_pkg::ADV_IMM32;
              end
              rme_pkg::LOAD_IMM8: begin
                val = imm8;
                adv = rme_pkg::ADV_IMM8;
              end
              rme_pkg::LOAD_MERGE32: begin
                val = (operand & rme_pkg::MASK_PARTIAL4) + imm32;
                adv = rme_pkg::ADV_IMM32;
              end
              rme_pkg::LOAD_MERGE8: begin
                val = (operand & rme_pkg::MASK_PARTIAL1) + imm8;
                adv = rme_pkg::ADV_IMM8;
              end
              default: begin
                wr  = 1'b0;
                bad = 1'b1;
              end
            endcase
          end else begin
            bad = 1'b1;
          end
        end
        rme_pkg::MAJOR_MUL: begin
          if (minor_op == rme_pkg::MUL_R0 || minor_op == rme_pkg::MUL_R1 ||
              minor_op == rme_pkg::MUL_R2 || minor_op == rme_pkg::MUL_R3) begin
            is_mul = 1'b1;
            wr     = 1'b1;
            wr_hi  = 1'b1;
            dest   = rme_pkg::read_index(major_op, minor_op);
            val    = mul_lo;
            hval   = mul_hi;
            adv    = rme_pkg::ADV_IMM64;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    if (bad) begin
      halt = 1'b1;
    end
    if (halt) begin
      wr    = 1'b0;
      wr_hi = 1'b0;
      val   = 64'd0;
      hval  = 64'd0;
      dest  = '0;
    end

    exec.is_mul     = is_mul && !halt;
    exec.next_ip    = halt ? ip : (ip + {60'd0, adv});
    exec.halted     = halt;
    exec.illegal    = bad;
    exec.wr         = wr;
    exec.dest_index = dest;
    exec.dest_value = val;
    exec.wr_hi      = wr_hi;
    exec.high_value = hval;
  end

endmodule

[sv/register_machine_execute_unit.sv]
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes fetched instructions on eight 64-bit registers and an
// instruction pointer, one result beat per instruction.
// ----------------------------------------------------------------------------
// Each accepted instruction beat is held in an input register and executed
// there, so a new instruction can be taken every cycle unless a multiply or a
// stalled result holds it. A multiply stays in the input register until done:
// its four 32x32 partial products are registered first and then summed, and no
// new instruction is taken before that. Results wait in an output
// register; while one waits, the input register can still take one
// instruction, and after that the input is held off until the result beat
// is taken.
// Writing cfg_wdata with cfg_we loads the instruction pointer and restarts a
// stopped machine; after a halt or an illegal opcode every further
// instruction reports halted until that write.
module register_machine_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  rme_instr_if.sink   instr,
  rme_result_if.source result
);

  logic                            s1_valid;
  logic [7:0]                      s1_major;
  logic [7:0]                      s1_minor;
  logic [63:0]                     s1_imm;
  logic                            mul_phase;
  logic [63:0]                     ip;
  logic                            stopped;
  logic [63:0]                     regs [rme_pkg::REGISTER_COUNT];
  logic [rme_pkg::REG_INDEX_W-1:0] rd_idx;
  logic [63:0]                     operand;
  logic [63:0]                     mul_lo;
  logic [63:0]                     mul_hi;
  logic                            need_mul;
  logic                            mul_start;
  logic                            consume;
  rme_pkg::exec_t                  exec;

  logic                            out_valid;
  logic [63:0]                     out_next_ip;
  logic                            out_halted;
  logic                            out_illegal;
  logic [2:0]                      out_dest_index;
  logic [63:0]                     out_dest_value;
  logic                            out_high_written;
  logic [63:0]                     out_high_value;

  assign rd_idx  = rme_pkg::read_index(s1_major, s1_minor);
  assign operand = regs[rd_idx];

  rme_decode u_decode (
    .stopped   (stopped),
    .ip        (ip),
    .major_op  (s1_major),
    .minor_op  (s1_minor),
    .immediate (s1_imm),
    .operand   (operand),
    .mul_lo    (mul_lo),
    .mul_hi    (mul_hi),
    .exec      (exec)
  );

  rme_mul u_mul (
    .clk  (clk),
    .load (mul_start),
    .a    (operand),
    .b    (s1_imm),
    .lo   (mul_lo),
    .hi   (mul_hi)
  );

  assign need_mul    = s1_valid && exec.is_mul;
  assign mul_start   = need_mul && !mul_phase;
  assign consume     = s1_valid && (!out_valid || result.ready) && (!need_mul || mul_phase);
  assign instr.ready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_major <= instr.major_op;
      s1_minor <= instr.minor_op;
      s1_imm   <= instr.immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_phase <= 1'b0;
    end else if (consume) begin
      mul_phase <= 1'b0;
    end else if (mul_start) begin
      mul_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip      <= 64'd0;
      stopped <= 1'b0;
    end else if (cfg_we) begin
      ip      <= cfg_wdata;
      stopped <= 1'b0;
    end else if (consume) begin
      ip      <= exec.next_ip;
      stopped <= exec.halted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rme_pkg::REGISTER_COUNT; i++) begin
        regs[i] <= 64'd0;
      end
    end else if (consume) begin
      if (exec.wr) begin
        regs[exec.dest_index] <= exec.dest_value;
      end
      if (exec.wr_hi) begin
        regs[{1'b1, exec.dest_index[rme_pkg::REG_INDEX_W-2:0]}] <= exec.high_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      out_next_ip      <= exec.next_ip;
      out_halted       <= exec.halted;
      out_illegal      <= exec.illegal;
      out_dest_index   <= 3'(exec.dest_index);
      out_dest_value   <= exec.dest_value;
      out_high_written <= exec.wr_hi;
      out_high_value   <= exec.high_value;
    end
  end

  assign result.valid        = out_valid;
  assign result.next_ip      = out_next_ip;
  assign result.halted       = out_halted;
  assign result.illegal      = out_illegal;
  assign result.dest_index   = out_dest_index;
  assign result.dest_value   = out_dest_value;
  assign result.high_written = out_high_written;
  assign result.high_value   = out_high_value;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the register machine execute unit. A driver sends
// instruction beats from a queue and a monitor compares every result beat
// with a prediction computed from a shadow register file, pointer and stop
// flag. The start address is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          RANDOM_ITEMS   = 800;
  localparam logic [2:0]  MUL_R3_REG     = 3'd3;
  localparam logic [63:0] ALL_ONES       = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [63:0] imm;
  } instr_t;

  typedef struct packed {
    logic [63:0] next_ip;
    logic        halted;
    logic        illegal;
    logic [2:0]  dest_index;
    logic [63:0] dest_value;
    logic        high_written;
    logic [63:0] high_value;
  } exec_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  rme_instr_if  instr_bus ();
  rme_result_if result_bus ();

  register_machine_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .instr     (instr_bus),
    .result    (result_bus)
  );

  logic [63:0]  reg_shadow [rme_pkg::REGISTER_COUNT];
  logic [63:0]  ip_shadow;
  logic         machine_stopped;

  instr_t       pending_instrs [$];
  exec_result_t expected_results [$];
  instr_t       drv_item;
  exec_result_t want;

  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;
  bit           hold_req;
  bit           hold_taken;
  int           hold_left;
  int           idle_cycles;
  int           error_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic exec_result_t execute_instr(input logic [7:0] major,
                                                 input logic [7:0] minor,
                                                 input logic [63:0] imm);
    exec_result_t res;
    logic [3:0]   hi_nib;
    logic [2:0]   r;
    logic [2:0]   dest;
    logic [63:0]  x;
    logic [63:0]  val;
    logic [63:0]  hval;
    logic [63:0]  adv;
    logic [127:0] product;
    logic         bad;
    logic         halt;
    logic         wr;
    logic         wr_hi;
    hi_nib = minor[7:4];
    r      = minor[2:0];
    x      = reg_shadow[r];
    bad    = 1'b0;
    halt   = 1'b0;
    wr     = 1'b0;
    wr_hi  = 1'b0;
    adv    = '0;
    val    = '0;
    hval   = '0;
    dest   = '0;
    if (machine_stopped) begin
      halt = 1'b1;
    end else if (major == rme_pkg::MAJOR_CTRL) begin
      if (minor == rme_pkg::MINOR_NOP) adv = 64'(rme_pkg::ADV_SHORT);
      else if (minor == rme_pkg::MINOR_HALT) halt = 1'b1;
      else bad = 1'b1;
    end else if (major == rme_pkg::MAJOR_ARITH && !minor[3]) begin
      wr   = 1'b1;
      dest = r;
      case (hi_nib)
        rme_pkg::ARITH_INC: begin
          val = x + 64'd1; adv = 64'(rme_pkg::ADV_SHORT);
        end
        rme_pkg::ARITH_DEC: begin
          val = x - 64'd1; adv = 64'(rme_pkg::ADV_SHORT);
        end
        rme_pkg::ARITH_ADD64: begin
          val = x + imm; adv = 64'(rme_pkg::ADV_IMM64);
        end
        rme_pkg::ARITH_ADD32: begin
          val = x + {32'b0, imm[31:0]}; adv = 64'(rme_pkg::ADV_IMM32);
        end
        rme_pkg::ARITH_ADD8: begin
          val = x + {56'b0, imm[7:0]}; adv = 64'(rme_pkg::ADV_IMM8);
        end
        rme_pkg::ARITH_SUB64: begin
          val = x - imm; adv = 64'(rme_pkg::ADV_IMM64);
        end
        rme_pkg::ARITH_SUB32: begin
          val = x - {32'b0, imm[31:0]}; adv = 64'(rme_pkg::ADV_IMM32);
        end
        rme_pkg::ARITH_SUB8: begin
          val = x - {56'b0, imm[7:0]}; adv = 64'(rme_pkg::ADV_IMM8);
        end
        default: begin wr = 1'b0; bad = 1'b1; end
      endcase
    end else if (major == rme_pkg::MAJOR_LOAD && !minor[3]) begin
      wr   = 1'b1;
      dest = r;
      case (hi_nib)
        rme_pkg::LOAD_IMM64: begin
          val = imm; adv = 64'(rme_pkg::ADV_IMM64);
        end
        rme_pkg::LOAD_IMM32: begin
          val = {32'b0, imm[31:0]}; adv = 64'(rme_pkg::ADV_IMM32);
        end
        rme_pkg::LOAD_IMM8: begin
          val = {56'b0, imm[7:0]}; adv = 64'(rme_pkg::ADV_IMM8);
        end
        rme_pkg::LOAD_MERGE32: begin
          val = (x & rme_pkg::MASK_PARTIAL4) + {32'b0, imm[31:0]};
          adv = 64'(rme_pkg::ADV_IMM32);
        end
        rme_pkg::LOAD_MERGE8: begin
          val = (x & rme_pkg::MASK_PARTIAL1) + {56'b0, imm[7:0]};
          adv = 64'(rme_pkg::ADV_IMM8);
        end
        default: begin wr = 1'b0; bad = 1'b1; end
      endcase
    end else if (major == rme_pkg::MAJOR_MUL &&
                 (minor == rme_pkg::MUL_R0 || minor == rme_pkg::MUL_R1 ||
                  minor == rme_pkg::MUL_R2 || minor == rme_pkg::MUL_R3)) begin
      dest    = (minor == rme_pkg::MUL_R3) ? MUL_R3_REG : minor[2:0];
      product = {64'b0, reg_shadow[dest]} * {64'b0, imm};
      val     = product[63:0];
      hval    = product[127:64];
      wr      = 1'b1;
      wr_hi   = 1'b1;
      adv     = 64'(rme_pkg::ADV_IMM64);
    end else begin
      bad = 1'b1;
    end
    if (bad) halt = 1'b1;
    if (halt) begin
      machine_stopped = 1'b1;
      wr    = 1'b0;
      wr_hi = 1'b0;
      val   = '0;
      hval  = '0;
      dest  = '0;
    end else begin
      if (wr) reg_shadow[dest] = val;
      if (wr_hi) reg_shadow[3'(dest + 3'd4)] = hval;
      ip_shadow = ip_shadow + adv;
    end
    res.next_ip      = ip_shadow;
    res.halted       = halt;
    res.illegal      = bad;
    res.dest_index   = dest;
    res.dest_value   = val;
    res.high_written = wr_hi;
    res.high_value   = hval;
    return res;
  endfunction

  function automatic logic [63:0] random_imm();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = ALL_ONES;
      1: v = '0;
      2: v[63:8] = '0;
      3: v[63:32] = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic instr_t legal_instr();
    instr_t     it;
    logic [3:0] op;
    logic [2:0] r;
    r      = 3'($urandom_range(7));
    it.imm = random_imm();
    op     = rme_pkg::ARITH_INC;
    case ($urandom_range(19))
      0: begin
        it.major = rme_pkg::MAJOR_CTRL;
        it.minor = rme_pkg::MINOR_NOP;
      end
      1, 2, 3, 4, 5, 6, 7, 8: begin
        case ($urandom_range(7))
          0: op = rme_pkg::ARITH_INC;
          1: op = rme_pkg::ARITH_DEC;
          2: op = rme_pkg::ARITH_ADD64;
          3: op = rme_pkg::ARITH_ADD32;
          4: op = rme_pkg::ARITH_ADD8;
          5: op = rme_pkg::ARITH_SUB64;
          6: op = rme_pkg::ARITH_SUB32;
          default: op = rme_pkg::ARITH_SUB8;
        endcase
        it.major = rme_pkg::MAJOR_ARITH;
        it.minor = {op, 1'b0, r};
      end
      9, 10, 11, 12, 13, 14, 15: begin
        case ($urandom_range(4))
          0: op = rme_pkg::LOAD_IMM64;
          1: op = rme_pkg::LOAD_IMM32;
          2: op = rme_pkg::LOAD_IMM8;
          3: op = rme_pkg::LOAD_MERGE32;
          default: op = rme_pkg::LOAD_MERGE8;
        endcase
        it.major = rme_pkg::MAJOR_LOAD;
        it.minor = {op, 1'b0, r};
      end
      default: begin
        it.major = rme_pkg::MAJOR_MUL;
        case ($urandom_range(3))
          0: it.minor = rme_pkg::MUL_R0;
          1: it.minor = rme_pkg::MUL_R1;
          2: it.minor = rme_pkg::MUL_R2;
          default: it.minor = rme_pkg::MUL_R3;
        endcase
      end
    endcase
    return it;
  endfunction

  function automatic instr_t noise_instr();
    instr_t it;
    it.major = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    it.minor = 8'($urandom_range(255));
    it.imm   = random_imm();
    return it;
  endfunction

  function automatic void queue_instr(input logic [7:0] major, input logic [7:0] minor,
                                      input logic [63:0] imm);
    instr_t it;
    it.major = major;
    it.minor = minor;
    it.imm   = imm;
    pending_instrs.push_back(it);
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_instrs.size() != 0 || instr_bus.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(input logic [63:0] addr);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    ip_shadow       = addr;
    machine_stopped = 1'b0;
  endtask

  // Driver: a new beat is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      instr_bus.valid <= 1'b0;
    end else if (!instr_bus.valid || instr_bus.ready) begin
      if (pending_instrs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = pending_instrs.pop_front();
        instr_bus.valid     <= 1'b1;
        instr_bus.major_op  <= drv_item.major;
        instr_bus.minor_op  <= drv_item.minor;
        instr_bus.immediate <= drv_item.imm;
      end else begin
        instr_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      hold_taken       <= 1'b0;
      hold_left        <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken       <= 1'b1;
      hold_left        <= HOLD_CYCLES;
      result_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on every accepted instruction beat, check every result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (instr_bus.valid && instr_bus.ready) begin
        expected_results.push_back(execute_instr(instr_bus.major_op, instr_bus.minor_op,
                                                 instr_bus.immediate));
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual next_ip %h",
                   $time, result_bus.next_ip);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("next_ip", want.next_ip, result_bus.next_ip);
          check_field("halted", 64'(want.halted), 64'(result_bus.halted));
          check_field("illegal", 64'(want.illegal), 64'(result_bus.illegal));
          check_field("dest_index", 64'(want.dest_index), 64'(result_bus.dest_index));
          check_field("dest_value", want.dest_value, result_bus.dest_value);
          check_field("high_written", 64'(want.high_written),
                      64'(result_bus.high_written));
          check_field("high_value", want.high_value, result_bus.high_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (instr_bus.valid && instr_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          issued;
    int          len;
    int          extra;
    bit          do_hold;
    logic [63:0] addr;
    instr_bus.valid     = 1'b0;
    instr_bus.major_op  = '0;
    instr_bus.minor_op  = '0;
    instr_bus.immediate = '0;
    result_bus.ready    = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    rst                 = 1'b1;
    hold_req            = 1'b0;
    idle_cycles         = 0;
    error_count         = 0;
    src_idle_pct        = 18;
    snk_idle_pct        = 75;
    for (int i = 0; i < rme_pkg::REGISTER_COUNT; i++) reg_shadow[i] = '0;
    ip_shadow       = '0;
    machine_stopped = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every operation with extreme operands, ending in a halt and an ignored beat.
    queue_instr(rme_pkg::MAJOR_CTRL, rme_pkg::MINOR_NOP, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_INC, 4'h0}, '0);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_DEC, 4'h1}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_ADD64, 4'h2}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_ADD32, 4'h3}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_ADD8, 4'h4}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_SUB64, 4'h5}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_SUB32, 4'h6}, 64'h0123_4567_89ab_cdef);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_SUB8, 4'h7}, 64'hffff_ffff_ffff_ff80);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_IMM64, 4'h0}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_IMM32, 4'h1}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_IMM8, 4'h2}, 64'h8000_0000_0000_005a);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_IMM64, 4'h3}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_MERGE32, 4'h3}, 64'hffff_ffff_1234_5678);
    queue_instr(rme_pkg::MAJOR_LOAD, {rme_pkg::LOAD_MERGE8, 4'h1}, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_MUL, rme_pkg::MUL_R0, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_MUL, rme_pkg::MUL_R1, ALL_ONES);
    queue_instr(rme_pkg::MAJOR_MUL, rme_pkg::MUL_R2, '0);
    queue_instr(rme_pkg::MAJOR_MUL, rme_pkg::MUL_R3, 64'hdead_beef_0bad_f00d);
    queue_instr(rme_pkg::MAJOR_CTRL, rme_pkg::MINOR_HALT, '0);
    queue_instr(rme_pkg::MAJOR_CTRL, rme_pkg::MINOR_NOP, '0);

    // Pointer wrap, then the unimplemented multiply variant and other illegal encodings.
    write_start(ALL_ONES);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_INC, 4'h0}, '0);
    queue_instr(rme_pkg::MAJOR_MUL, 8'h03, ALL_ONES);
    write_start(64'h8000_0000_0000_0000);
    queue_instr(rme_pkg::MAJOR_CTRL, 8'h02, '0);
    write_start(64'h0000_0000_0000_1000);
    queue_instr(rme_pkg::MAJOR_ARITH, {rme_pkg::ARITH_INC, 4'h8}, '0);
    write_start(64'h7fff_ffff_ffff_fff0);
    queue_instr(rme_pkg::MAJOR_LOAD, 8'h20, ALL_ONES);

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      wait_drained();
      if (issued >= (2 * RANDOM_ITEMS) / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (issued >= RANDOM_ITEMS / 3) begin
        src_idle_pct = 75;
        snk_idle_pct = 18;
      end
      case ($urandom_range(4))
        0: addr = '0;
        1: addr = ALL_ONES;
        2: addr = ALL_ONES - 64'($urandom_range(30));
        default: addr = {$urandom, $urandom};
      endcase
      write_start(addr);
      do_hold = (issued >= (2 * RANDOM_ITEMS) / 3) && !hold_req;
      len = do_hold ? 120 : $urandom_range(8, 40);
      for (int i = 0; i < len; i++) pending_instrs.push_back(legal_instr());
      issued += len;
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(9) < 3) begin
          queue_instr(rme_pkg::MAJOR_CTRL, rme_pkg::MINOR_HALT, random_imm());
        end else begin
          pending_instrs.push_back(noise_instr());
        end
        issued++;
        extra = $urandom_range(3);
        for (int i = 0; i < extra; i++) pending_instrs.push_back(noise_instr());
      end
      if (do_hold) hold_req = 1'b1;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
